/* rtl/core/pal_pkg.sv */
// Package for the positional array list: payload structs, operation codes
// and shared constants. No dependencies.
package pal_pkg;

    localparam int PAL_CAPACITY   = 64;
    localparam int PAL_DATA_WIDTH = 32;
    localparam int FUNC_W         = 3;
    localparam int POS_W          = 7;
    localparam int VAL_W          = 32;
    localparam int LEN_W          = 7;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 3'd0,
        FUNC_GET    = 3'd1,
        FUNC_SET    = 3'd2,
        FUNC_REMOVE = 3'd3,
        FUNC_CLEAR  = 3'd4
    } t_func;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [POS_W-1:0]  position;
        logic [VAL_W-1:0]  value;
    } t_pal_in;

    typedef struct packed {
        logic             ok;
        logic [VAL_W-1:0] read_value;
        logic [LEN_W-1:0] length;
        logic             empty_res;
    } t_pal_out;

    // Operation broadcast to every cell of the chain for one transfer.
    typedef struct packed {
        logic shift_up;
        logic shift_down;
        logic load_value;
    } t_cell_ctl;

endpackage

/* rtl/core/pal_cell.sv */
// One entry cell of the list chain: holds one entry and takes its next
// value from itself, the input value or a neighbor. Depends on pal_pkg.
module pal_cell import pal_pkg::*; #(
    parameter int DATA_WIDTH = PAL_DATA_WIDTH,
    parameter int IDX_W      = 6,
    parameter int INDEX      = 0
) (
    input  logic                  i_clk,
    input  t_cell_ctl             i_ctl,
    input  logic [IDX_W-1:0]      i_pos_idx,
    input  logic [DATA_WIDTH-1:0] i_value,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    output logic [DATA_WIDTH-1:0] o_entry,
    output logic [DATA_WIDTH-1:0] o_tap
);

    logic [DATA_WIDTH-1:0] r_entry;
    logic [DATA_WIDTH-1:0] n_entry;
    logic                  w_at;
    logic                  w_after;

    assign w_at    = (i_pos_idx == IDX_W'(INDEX));
    assign w_after = (IDX_W'(INDEX) > i_pos_idx);

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.shift_up) begin
            if (w_at) begin
                n_entry = i_value;
            end else if (w_after) begin
                n_entry = i_left;
            end
        end else if (i_ctl.shift_down) begin
            if (w_at || w_after) begin
                n_entry = i_right;
            end
        end else if (i_ctl.load_value && w_at) begin
            n_entry = i_value;
        end
    end

    // Entries hold no reset value; only written entries are ever read.
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_tap   = w_at ? r_entry : '0;

endmodule

/* rtl/core/positional_array_list.sv */
// Top level of the positional array list: a chain of entry cells, the
// count register, operation decode and the result register. Depends on
// pal_pkg and pal_cell.
//
//   channel   valid    ready    payload   direction
//   input     i_valid  o_ready  i_data    into the block
//   result    o_valid  i_ready  o_data    out of the block
//
// Every operation updates the list at the edge of its transfer, and its result
// is valid from the next cycle; one item per cycle while the receiver takes results.
// Insert and remove shift all cells after the position at once through the
// neighbor links, so every operation completes at the edge of its transfer.
// Reset clears the count and the result valid; entries are left as they are.
// A result waits in the output register; a new item is taken in the same
// cycle that the waiting result is taken.
module positional_array_list import pal_pkg::*; #(
    parameter int CAPACITY   = PAL_CAPACITY,
    parameter int DATA_WIDTH = PAL_DATA_WIDTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_pal_in  i_data,
    output logic     o_valid,
    input  logic     i_ready,
    output t_pal_out o_data
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

    logic                  r_out_valid;
    t_pal_out              r_out;
    t_pal_out              n_out;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  w_fire;
    t_func                 w_func;
    logic [PW-1:0]         w_pos;
    logic [PW-1:0]         w_cnt;
    logic                  w_ins_ok;
    logic                  w_in_range;
    logic                  w_ok;
    t_cell_ctl             w_ctl;
    logic [IW-1:0]         w_pos_idx;
    logic [DATA_WIDTH-1:0] w_value;
    logic [DATA_WIDTH-1:0] w_entry [CAPACITY];
    logic [DATA_WIDTH-1:0] w_tap   [CAPACITY];
    logic [DATA_WIDTH-1:0] w_rd;

    assign o_ready = !r_out_valid || i_ready;
    assign w_fire  = i_valid && o_ready;
    assign w_func  = t_func'(i_data.func);
    assign w_pos   = PW'(i_data.position);
    assign w_cnt   = PW'(r_count);
    assign w_value = DATA_WIDTH'(i_data.value);

    assign w_ins_ok   = (w_pos != '0) && (w_pos <= w_cnt + PW'(1))
                        && (r_count < CW'(CAPACITY));
    assign w_in_range = (w_pos != '0) && (w_pos <= w_cnt);

    // A valid position minus one is always below CAPACITY, so the low bits suffice.
    assign w_pos_idx = IW'(w_pos - PW'(1));

    always_comb begin
        w_ok    = 1'b0;
        n_count = r_count;
        unique case (w_func)
            FUNC_INSERT: begin
                w_ok = w_ins_ok;
                if (w_ins_ok) begin
                    n_count = r_count + CW'(1);
                end
            end
            FUNC_GET, FUNC_SET: begin
                w_ok = w_in_range;
            end
            FUNC_REMOVE: begin
                w_ok = w_in_range;
                if (w_in_range) begin
                    n_count = r_count - CW'(1);
                end
            end
            FUNC_CLEAR: begin
                w_ok    = 1'b1;
                n_count = '0;
            end
            default: begin
                w_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        w_ctl            = '0;
        w_ctl.shift_up   = w_fire && w_ok && (w_func == FUNC_INSERT);
        w_ctl.shift_down = w_fire && w_ok && (w_func == FUNC_REMOVE);
        w_ctl.load_value = w_fire && w_ok && (w_func == FUNC_SET);
    end

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left;
        logic [DATA_WIDTH-1:0] w_right;
        if (k == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_entry[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_entry[k+1];
        end
        pal_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX_W      (IW),
            .INDEX      (k)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_pos_idx (w_pos_idx),
            .i_value   (w_value),
            .i_left    (w_left),
            .i_right   (w_right),
            .o_entry   (w_entry[k]),
            .o_tap     (w_tap[k])
        );
    end

    // Only the addressed cell drives a nonzero tap, so an OR tree selects it.
    always_comb begin
        w_rd = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_rd = w_rd | w_tap[k];
        end
    end

    always_comb begin
        n_out            = '0;
        n_out.ok         = w_ok;
        n_out.read_value = (w_ok && (w_func == FUNC_GET)) ? VAL_W'(w_rd) : '0;
        n_out.length     = LEN_W'(n_count);
        n_out.empty_res  = (n_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (w_fire) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("list count exceeds capacity");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (w_func == FUNC_CLEAR)) |=>
            (o_valid && o_data.ok && o_data.empty_res && (r_count == '0)))
        else $error("clear did not empty the list");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (w_func == FUNC_INSERT) && w_ins_ok) |=>
            (r_count == $past(r_count) + CW'(1)))
        else $error("accepted insert did not grow the list");

endmodule

/* bench/positional_array_list_test.sv */
// Self-checking testbench for positional_array_list: directed, full-list and random
// transfers with a local model of the list. Depends on pal_pkg and positional_array_list.
`timescale 1ns / 100ps

module positional_array_list_test;
    import pal_pkg::*;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    logic     i_ready = 1'b0;
    t_pal_in  i_data  = '0;
    logic     o_ready;
    logic     o_valid;
    t_pal_out o_data;

    // Local model of the list contents and length.
    logic [VAL_W-1:0] list_mem [PAL_CAPACITY];
    int               list_len = 0;
    t_pal_out         due_results [$];
    int               error_count = 0;

    // Idle controls shared by the test tasks and the receiver process.
    bit tx_idle_on    = 1'b1;
    bit rx_idle_on    = 1'b1;
    int rx_hold_left  = 0;
    int rx_stall_left = 0;

    positional_array_list dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("positional_array_list regression: fail");
        $finish;
    end

    task automatic flag_error(string msg);
        error_count++;
        if (error_count <= 40) begin
            $display("ERROR at %0t ns: %s", $time, msg);
        end
    endtask

    function automatic t_pal_out apply_list_op(t_pal_in item);
        t_pal_out r;
        int       p;
        r = '0;
        p = item.position;
        case (item.func)
            FUNC_INSERT: begin
                if (p >= 1 && p <= list_len + 1 && list_len < PAL_CAPACITY) begin
                    for (int i = list_len; i >= p; i--) list_mem[i] = list_mem[i-1];
                    list_mem[p-1] = item.value;
                    list_len++;
                    r.ok = 1'b1;
                end
            end
            FUNC_GET: begin
                if (p >= 1 && p <= list_len) begin
                    r.read_value = list_mem[p-1];
                    r.ok         = 1'b1;
                end
            end
            FUNC_SET: begin
                if (p >= 1 && p <= list_len) begin
                    list_mem[p-1] = item.value;
                    r.ok          = 1'b1;
                end
            end
            FUNC_REMOVE: begin
                if (p >= 1 && p <= list_len) begin
                    for (int i = p; i < list_len; i++) list_mem[i-1] = list_mem[i];
                    list_len--;
                    r.ok = 1'b1;
                end
            end
            FUNC_CLEAR: begin
                list_len = 0;
                r.ok     = 1'b1;
            end
            default: ;
        endcase
        r.length    = LEN_W'(list_len);
        r.empty_res = (list_len == 0);
        return r;
    endfunction

    // The result is checked before the new transfer is modeled, so a result and an
    // input transfer on the same edge never trade places in the queue.
    always @(posedge i_clk) begin
        t_pal_out want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (due_results.size() == 0) begin
                    flag_error($sformatf("result with nothing pending: %p", o_data));
                end else begin
                    want = due_results.pop_front();
                    if (o_data.ok !== want.ok)
                        flag_error($sformatf("ok %b, want %b", o_data.ok, want.ok));
                    if (o_data.read_value !== want.read_value)
                        flag_error($sformatf("read_value %h, want %h",
                                             o_data.read_value, want.read_value));
                    if (o_data.length !== want.length)
                        flag_error($sformatf("length %0d, want %0d",
                                             o_data.length, want.length));
                    if (o_data.empty_res !== want.empty_res)
                        flag_error($sformatf("empty_res %b, want %b",
                                             o_data.empty_res, want.empty_res));
                end
            end
            if (i_valid && o_ready) begin
                due_results.push_back(apply_list_op(i_data));
            end
        end
    end

    // Receiver: a long hold when asked, otherwise random stall bursts.
    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_ready = 1'b0;
        end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            i_ready = 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            rx_stall_left = $urandom_range(0, 13);
            i_ready       = 1'b0;
        end else begin
            i_ready = 1'b1;
        end
    end

    // Called right after a transfer, so the first lowering of valid lands on the
    // very next falling edge and the accepted item is never offered twice.
    task automatic pause_sender_maybe();
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 14)) begin
                @(negedge i_clk);
                i_valid = 1'b0;
            end
        end
    endtask

    // Must be entered at a falling edge; returns at the edge of the transfer.
    task automatic drive_item(t_pal_in item);
        i_valid = 1'b1;
        i_data  = item;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send_item(logic [FUNC_W-1:0] func, int pos, logic [VAL_W-1:0] value);
        t_pal_in item;
        item.func     = func;
        item.position = POS_W'(pos);
        item.value    = value;
        pause_sender_maybe();
        @(negedge i_clk);
        drive_item(item);
    endtask

    // The position is picked at the falling edge, when the model length already
    // includes every earlier transfer.
    task automatic send_random_op(int noise_w, int clear_w, int insert_w, int remove_w);
        t_pal_in item;
        int      pick;
        int      top;
        pause_sender_maybe();
        @(negedge i_clk);
        pick       = $urandom_range(0, 99);
        item.value = $urandom();
        if (pick < noise_w) begin
            item.func     = FUNC_W'($urandom_range(0, 2**FUNC_W - 1));
            item.position = POS_W'($urandom_range(0, 2**POS_W - 1));
        end else if (pick < noise_w + clear_w) begin
            item.func     = FUNC_CLEAR;
            item.position = POS_W'($urandom_range(0, 2**POS_W - 1));
        end else begin
            top = list_len;
            if (pick < noise_w + clear_w + insert_w) begin
                item.func = FUNC_INSERT;
                top       = list_len + 1;
            end else if (pick < noise_w + clear_w + insert_w + remove_w) begin
                item.func = FUNC_REMOVE;
            end else begin
                item.func = $urandom_range(0, 1) ? FUNC_GET : FUNC_SET;
            end
            case ($urandom_range(0, 9))
                0:       item.position = '0;
                1:       item.position = POS_W'(top + 1);
                2:       item.position = POS_W'(top);
                default: item.position = POS_W'((top == 0) ? 1 : $urandom_range(1, top));
            endcase
        end
        drive_item(item);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed_cases();
        // On an empty list everything but insert at the front and clear is rejected.
        send_item(FUNC_GET, 1, '0);
        send_item(FUNC_REMOVE, 1, '0);
        send_item(FUNC_SET, 1, '1);
        send_item(FUNC_INSERT, 0, '1);
        send_item(FUNC_INSERT, 2, '1);
        send_item(FUNC_INSERT, 1, '0);
        send_item(FUNC_INSERT, 1, '1);
        send_item(FUNC_INSERT, 3, 32'h5A5A_5A5A);
        send_item(FUNC_INSERT, 2, 32'h1234_5678);
        for (int p = 1; p <= 5; p++) send_item(FUNC_GET, p, '0);
        send_item(FUNC_SET, 4, 32'hA5A5_A5A5);
        send_item(FUNC_GET, 4, '0);
        send_item(FUNC_SET, 0, '1);
        send_item(FUNC_REMOVE, 2, '0);
        send_item(FUNC_REMOVE, 1, '0);
        send_item(FUNC_REMOVE, 2, '0);
        send_item(FUNC_GET, 2**POS_W - 1, '0);
        for (int f = FUNC_CLEAR + 1; f < 2**FUNC_W; f++) send_item(FUNC_W'(f), 1, '1);
        send_item(FUNC_CLEAR, 2**POS_W - 1, '1);
        send_item(FUNC_GET, 1, '0);
        send_item(FUNC_INSERT, 1, 32'h8000_0001);
    endtask

    // The receiver holds off while inserts keep coming, so the block stalls its
    // input; the list then fills up and the full-list cases follow.
    task automatic test_full_list_under_stall();
        wait_drained();
        rx_hold_left = 250;
        tx_idle_on   = 1'b0;
        repeat (2 * PAL_CAPACITY) send_random_op(0, 0, 100, 0);
        tx_idle_on = 1'b1;
        send_item(FUNC_INSERT, PAL_CAPACITY + 1, '1);
        send_item(FUNC_INSERT, 1, '1);
        send_item(FUNC_GET, PAL_CAPACITY, '0);
        send_item(FUNC_SET, PAL_CAPACITY, '1);
        send_item(FUNC_GET, PAL_CAPACITY, '0);
        send_item(FUNC_GET, PAL_CAPACITY + 1, '0);
        send_item(FUNC_REMOVE, PAL_CAPACITY, '0);
        send_item(FUNC_INSERT, PAL_CAPACITY, 32'hC0DE_0040);
        send_item(FUNC_REMOVE, 1, '0);
        send_item(FUNC_GET, 1, '0);
    endtask

    // Blocks alternate between growing and shrinking the list so its length sweeps
    // the whole range; every few blocks the sender waits for all results.
    task automatic test_random_traffic();
        for (int blk = 0; blk < 10; blk++) begin
            tx_idle_on = (blk % 3 != 1);
            rx_idle_on = (blk % 3 != 2);
            repeat (150) begin
                if (blk % 2 == 0) send_random_op(4, 1, 55, 10);
                else send_random_op(4, 1, 15, 50);
            end
            if (blk % 4 == 3) wait_drained();
        end
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (200) send_random_op(4, 1, 40, 30);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed_cases();
        test_full_list_under_stall();
        test_random_traffic();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("positional_array_list regression: pass");
        end else begin
            $display("positional_array_list regression: fail");
        end
        $finish;
    end

endmodule

/* positional_array_list.f */
rtl/core/pal_pkg.sv
rtl/core/pal_cell.sv
rtl/core/positional_array_list.sv
bench/positional_array_list_test.sv
